>>> hdl/float_frame_checker_decoder_assert.svh
// Assertion helpers used by the frame decoder's emitter file.
// All checks are sampled on clk and disabled while rst is high.
`ifndef FLOAT_FRAME_CHECKER_DECODER_ASSERT_SVH
`define FLOAT_FRAME_CHECKER_DECODER_ASSERT_SVH

// Same-cycle implication.
`define FFCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ffcd_pkg.sv
`timescale 1ns / 1ps
package ffcd_pkg;

  localparam int WORD_COUNT = 8;
  localparam int PAY_BYTES  = WORD_COUNT * 4;

  // Byte positions inside a frame
  localparam int POS_HDR0 = 0;
  localparam int POS_HDR1 = 1;
  localparam int POS_CMD  = 2;
  localparam int POS_SEQ  = 3;
  localparam int POS_PAY  = 4;
  localparam int POS_SUM  = POS_PAY + PAY_BYTES;
  localparam int POS_TAIL = POS_SUM + 1;

  localparam int POS_W     = $clog2(POS_TAIL + 1);
  localparam int PAY_IDX_W = $clog2(PAY_BYTES);
  localparam int IDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WIDX_W    = 3;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam logic [7:0] TAIL_MARK  = 8'h7F;

  // Byte 0 sits in the low lane, so the same bits read as little-endian words.
  typedef logic [PAY_BYTES-1:0][7:0]  pay_bytes_t;
  typedef logic [WORD_COUNT-1:0][31:0] pay_words_t;

  // Frame verdict handed from the framer to the result side on the tail byte.
  typedef struct packed {
    logic       fire;
    logic       good;
    logic [7:0] cmd;
    logic [7:0] seq;
  } tail_evt_t;

endpackage

>>> hdl/ffcd_framer.sv
`timescale 1ns / 1ps
module ffcd_framer
  import ffcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  output logic       at_tail,
  output tail_evt_t  evt,
  output pay_bytes_t pay_bytes
);

  logic [POS_W-1:0]     position;
  logic [POS_W-1:0]     position_next;
  logic [7:0]           running_sum;
  logic [7:0]           running_sum_next;
  logic                 header_good;
  logic                 header_good_next;
  logic [7:0]           held_cmd;
  logic [7:0]           held_cmd_next;
  logic [7:0]           held_seq;
  logic [7:0]           held_seq_next;
  logic [7:0]           held_checksum;
  logic [7:0]           held_checksum_next;
  pay_bytes_t           payload_store;

  logic [POS_W-1:0]     p;
  logic [POS_W-1:0]     pay_off;
  logic [PAY_IDX_W-1:0] pay_idx;
  logic                 in_payload;
  logic                 is_tail;

  assign p          = frame_start ? '0 : position;
  assign pay_off    = p - POS_W'(POS_PAY);
  assign pay_idx    = pay_off[PAY_IDX_W-1:0];
  assign in_payload = (p >= POS_W'(POS_PAY)) && (p < POS_W'(POS_SUM));
  assign is_tail    = (p == POS_W'(POS_TAIL));

  always_comb begin
    position_next      = position;
    running_sum_next   = running_sum;
    header_good_next   = header_good;
    held_cmd_next      = held_cmd;
    held_seq_next      = held_seq;
    held_checksum_next = held_checksum;
    if (accept) begin
      position_next = is_tail ? '0 : p + POS_W'(1);
      if (p == POS_W'(POS_HDR0)) begin
        header_good_next = (rx_byte == HDR_FIRST);
      end else if (p == POS_W'(POS_HDR1)) begin
        header_good_next = header_good && (rx_byte == HDR_SECOND);
      end else if (p == POS_W'(POS_CMD)) begin
        held_cmd_next    = rx_byte;
        running_sum_next = rx_byte;
      end else if (p == POS_W'(POS_SEQ)) begin
        held_seq_next    = rx_byte;
        running_sum_next = running_sum + rx_byte;
      end else if (in_payload) begin
        running_sum_next = running_sum + rx_byte;
      end else if (p == POS_W'(POS_SUM)) begin
        held_checksum_next = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      running_sum   <= '0;
      header_good   <= 1'b0;
      held_cmd      <= '0;
      held_seq      <= '0;
      held_checksum <= '0;
    end else begin
      position      <= position_next;
      running_sum   <= running_sum_next;
      header_good   <= header_good_next;
      held_cmd      <= held_cmd_next;
      held_seq      <= held_seq_next;
      held_checksum <= held_checksum_next;
    end
  end

  // Payload bytes; every lane is rewritten before any tail can be reached.
  always_ff @(posedge clk) begin
    if (accept && in_payload) begin
      payload_store[pay_idx] <= rx_byte;
    end
  end

  assign at_tail   = (position == POS_W'(POS_TAIL));
  assign evt.fire  = accept && is_tail;
  assign evt.good  = header_good && (rx_byte == TAIL_MARK) && (running_sum == held_checksum);
  assign evt.cmd   = held_cmd;
  assign evt.seq   = held_seq;
  assign pay_bytes = payload_store;

endmodule

>>> hdl/ffcd_emitter.sv
`timescale 1ns / 1ps
`include "float_frame_checker_decoder_assert.svh"
module ffcd_emitter
  import ffcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tail_evt_t         evt,
  input  pay_bytes_t        pay_bytes,
  input  logic              out_stall,
  output logic              pend,
  output logic              out_valid,
  output logic              ok,
  output logic [7:0]        cmd_byte,
  output logic [7:0]        seq_byte,
  output logic [WIDX_W-1:0] word_index,
  output logic [31:0]       payload_word,
  output logic              last
);

  logic [IDX_W-1:0] idx;
  logic             snap_good;
  logic [7:0]       snap_cmd;
  logic [7:0]       snap_seq;
  pay_words_t       snap_words;
  logic             load_out;
  logic             cur_last;

  assign load_out = !out_valid || !out_stall;
  assign cur_last = !snap_good || (idx == IDX_W'(WORD_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= pend;
      end
      if (evt.fire) begin
        pend <= 1'b1;
        idx  <= '0;
      end else if (load_out && pend) begin
        if (cur_last) begin
          pend <= 1'b0;
        end
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // Snapshot frees the payload store for the next frame right away.
  always_ff @(posedge clk) begin
    if (evt.fire) begin
      snap_good  <= evt.good;
      snap_cmd   <= evt.cmd;
      snap_seq   <= evt.seq;
      snap_words <= pay_words_t'(pay_bytes);
    end
    if (load_out && pend) begin
      ok           <= snap_good;
      cmd_byte     <= snap_good ? snap_cmd : '0;
      seq_byte     <= snap_good ? snap_seq : '0;
      word_index   <= snap_good ? WIDX_W'(idx) : '0;
      payload_word <= snap_good ? snap_words[idx] : '0;
      last         <= cur_last;
    end
  end

  `FFCD_ASSERT_NOW(a_no_overrun, evt.fire, !pend, "new frame verdict while results pending")
  `FFCD_ASSERT_NOW(a_fail_is_last, out_valid && !ok, last, "failure result without last")
  `FFCD_ASSERT_NEXT(a_last_clears, load_out && pend && cur_last, !pend, "pending not cleared")
  `FFCD_ASSERT_NOW(a_idx_range, pend, idx <= IDX_W'(WORD_COUNT - 1), "word index out of range")

endmodule

>>> hdl/float_frame_checker_decoder.sv
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// input    in_valid / in_stall  rx_byte, frame_start
// output   out_valid / out_stall ok, cmd_byte, seq_byte, word_index, payload_word, last
//
// One byte is taken per cycle unless in_stall holds it. A byte's state update and the
// frame verdict sit between the framer registers; results leave through a one-deep
// output register. A good frame gives WORD_COUNT results, one per cycle unless
// out_stall holds them; a bad one gives a single one. rst is synchronous and clears
// position, sums and the result queue. in_stall rises only when the tail byte is
// due while the previous frame's results are still queued behind a stalled output.
module float_frame_checker_decoder
  import ffcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [7:0]        cmd_byte,
  output logic [7:0]        seq_byte,
  output logic [WIDX_W-1:0] word_index,
  output logic [31:0]       payload_word,
  output logic              last
);

  logic       accept;
  logic       at_tail;
  logic       pend;
  tail_evt_t  evt;
  pay_bytes_t pay_bytes;

  // Hold off only a possible tail byte; the snapshot must be free by then.
  assign in_stall = pend && at_tail;
  assign accept   = in_valid && !in_stall;

  // Position tracking, running checksum, payload buffer.
  ffcd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .at_tail     (at_tail),
    .evt         (evt),
    .pay_bytes   (pay_bytes)
  );

  // Snapshot of a finished frame and the result output register.
  ffcd_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .evt          (evt),
    .pay_bytes    (pay_bytes),
    .out_stall    (out_stall),
    .pend         (pend),
    .out_valid    (out_valid),
    .ok           (ok),
    .cmd_byte     (cmd_byte),
    .seq_byte     (seq_byte),
    .word_index   (word_index),
    .payload_word (payload_word),
    .last         (last)
  );

endmodule

>>> tb/frame_result_checker.sv
`timescale 1ns / 1ps
module frame_result_checker
  import ffcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              frame_start,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              ok,
  input  logic [7:0]        cmd_byte,
  input  logic [7:0]        seq_byte,
  input  logic [WIDX_W-1:0] word_index,
  input  logic [31:0]       payload_word,
  input  logic              last,
  input  logic              run_done,
  output int                error_count,
  output int                pending_results
);

  typedef struct packed {
    logic              ok;
    logic [7:0]        cmd;
    logic [7:0]        seq;
    logic [WIDX_W-1:0] idx;
    logic [31:0]       word;
    logic              last;
  } frame_result_t;

  frame_result_t result_q[$];

  // Shadow of the decoder state
  int unsigned frame_pos;
  logic [7:0]  running_sum;
  logic [7:0]  held_cmd;
  logic [7:0]  held_seq;
  logic [7:0]  held_sum;
  logic        hdr_match;
  logic [7:0]  pay_store [PAY_BYTES];
  logic        leftovers_flagged;

  initial begin
    error_count = 0;
    pending_results = 0;
  end

  // One line per mismatch, and count it.
  task automatic flag_error(input string what);
    error_count++;
    $display("ERROR t=%0t %s", $time, what);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fs);
    frame_result_t r;
    int w;
    if (fs) frame_pos = 0;
    if (frame_pos > POS_TAIL) frame_pos = 0;
    if (frame_pos == POS_HDR0) begin
      hdr_match = (b == HDR_FIRST);
    end else if (frame_pos == POS_HDR1) begin
      hdr_match = hdr_match && (b == HDR_SECOND);
    end else if (frame_pos == POS_CMD) begin
      held_cmd = b;
      running_sum = b;
    end else if (frame_pos == POS_SEQ) begin
      held_seq = b;
      running_sum = running_sum + b;
    end else if (frame_pos < POS_SUM) begin
      pay_store[frame_pos - POS_PAY] = b;
      running_sum = running_sum + b;
    end else if (frame_pos == POS_SUM) begin
      held_sum = b;
    end

    if (frame_pos != POS_TAIL) begin
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (hdr_match && b == TAIL_MARK && running_sum == held_sum) begin
        for (w = 0; w < WORD_COUNT; w++) begin
          r.ok   = 1'b1;
          r.cmd  = held_cmd;
          r.seq  = held_seq;
          r.idx  = WIDX_W'(w);
          r.word = {pay_store[4*w+3], pay_store[4*w+2], pay_store[4*w+1], pay_store[4*w]};
          r.last = (w == WORD_COUNT - 1);
          result_q.push_back(r);
        end
      end else begin
        r = '0;
        r.last = 1'b1;
        result_q.push_back(r);
      end
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (result_q.size() == 0) begin
      flag_error($sformatf("result with none pending: ok=%b idx=%0d word=%h",
                           ok, word_index, payload_word));
    end else begin
      want = result_q.pop_front();
      if (ok !== want.ok)
        flag_error($sformatf("ok got %b want %b", ok, want.ok));
      if (cmd_byte !== want.cmd)
        flag_error($sformatf("cmd_byte got %h want %h", cmd_byte, want.cmd));
      if (seq_byte !== want.seq)
        flag_error($sformatf("seq_byte got %h want %h", seq_byte, want.seq));
      if (word_index !== want.idx)
        flag_error($sformatf("word_index got %0d want %0d", word_index, want.idx));
      if (payload_word !== want.word)
        flag_error($sformatf("payload_word got %h want %h", payload_word, want.word));
      if (last !== want.last)
        flag_error($sformatf("last got %b want %b", last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_pos = 0;
      running_sum = '0;
      held_cmd = '0;
      held_seq = '0;
      held_sum = '0;
      hdr_match = 1'b0;
      leftovers_flagged = 1'b0;
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_byte(rx_byte, frame_start);
      if (out_valid && !out_stall) check_result();
      if (run_done && !leftovers_flagged) begin
        leftovers_flagged = 1'b1;
        foreach (result_q[i])
          flag_error($sformatf("result never came: ok=%b idx=%0d word=%h",
                               result_q[i].ok, result_q[i].idx, result_q[i].word));
      end
    end
    pending_results <= result_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Frame decoder bench: builds whole frames (good, corrupted, restarted,
// unaligned noise), streams them byte by byte and lets the checker compare
// every result against its own decode of the accepted bytes.
module tb;
  import ffcd_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int ITEM_TARGET  = 270;     // total byte budget for the run
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int TAIL_WAIT    = 16;      // settle time after the last result
  localparam int CYCLE_LIMIT  = 200000;

  // How a frame gets mangled on its way in
  typedef enum int {
    FR_GOOD,
    FR_NO_START,   // well formed, but no start flag on byte 0
    FR_BAD_HDR0,
    FR_BAD_HDR1,
    FR_BAD_TAIL,
    FR_BAD_SUM,
    FR_RESTART     // partial frame, then start flag mid-frame
  } frame_kind_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = '0;
  logic              frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              ok;
  logic [7:0]        cmd_byte;
  logic [7:0]        seq_byte;
  logic [WIDX_W-1:0] word_index;
  logic [31:0]       payload_word;
  logic              last;

  logic run_done = 1'b0;
  int   error_count;
  int   pending_results;

  // idling knobs; percent of cycles
  int   send_idle_pct = 0;
  int   stall_pct = 0;

  // toggle hold_req to ask the receiver for one long hold-off
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;

  int   items_sent = 0;
  int   cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  float_frame_checker_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .cmd_byte     (cmd_byte),
    .seq_byte     (seq_byte),
    .word_index   (word_index),
    .payload_word (payload_word),
    .last         (last)
  );

  frame_result_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ok              (ok),
    .cmd_byte        (cmd_byte),
    .seq_byte        (seq_byte),
    .word_index      (word_index),
    .payload_word    (payload_word),
    .last            (last),
    .run_done        (run_done),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side. Random stall per cycle; on request one long hold-off,
  // counted here, while the sender keeps pushing bytes. The decoder's
  // one-deep result path then backs up and in_stall has to rise at the tail.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_ack = hold_req;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    stall_pct <= rcv;
  endtask

  // One item: random idle cycles first, then hold the byte until taken.
  // Returns on the edge where it was accepted.
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Raw bytes with the odd start flag; knocks the decoder off alignment.
  task automatic send_noise(input int count);
    int i;
    for (i = 0; i < count; i++)
      send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [7:0] cmd,
                            input logic [7:0] seq, input fill_e fill, input int cut);
    logic [7:0] fr [0:POS_TAIL];
    logic [7:0] sum;
    int i;
    fr[POS_HDR0] = HDR_FIRST;
    fr[POS_HDR1] = HDR_SECOND;
    fr[POS_CMD]  = cmd;
    fr[POS_SEQ]  = seq;
    sum = cmd + seq;
    for (i = 0; i < PAY_BYTES; i++) begin
      case (fill)
        FILL_ZERO: fr[POS_PAY+i] = 8'h00;
        FILL_ONES: fr[POS_PAY+i] = 8'hFF;
        default:   fr[POS_PAY+i] = 8'($urandom);
      endcase
      sum = sum + fr[POS_PAY+i];
    end
    fr[POS_SUM]  = sum;
    fr[POS_TAIL] = TAIL_MARK;

    // Corruptions flip at least one bit so the byte can never match.
    case (kind)
      FR_BAD_HDR0: fr[POS_HDR0] = fr[POS_HDR0] ^ 8'($urandom_range(1, 255));
      FR_BAD_HDR1: fr[POS_HDR1] = fr[POS_HDR1] ^ 8'($urandom_range(1, 255));
      FR_BAD_TAIL: fr[POS_TAIL] = fr[POS_TAIL] ^ 8'($urandom_range(1, 255));
      FR_BAD_SUM:  fr[POS_SUM]  = fr[POS_SUM]  ^ 8'($urandom_range(1, 255));
      default: ;
    endcase

    // Restart: feed a leading chunk, then begin again from byte 0.
    if (kind == FR_RESTART)
      for (i = 0; i < cut; i++) send_byte(fr[i], (i == 0));

    for (i = 0; i <= POS_TAIL; i++)
      send_byte(fr[i], (i == 0) && (kind != FR_NO_START));
  endtask

  // Sender stops and waits until every predicted result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  initial begin
    frame_kind_e kind;
    fill_e       fill;
    int          pick;
    int          frame_no;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed frames, no idling: all-zero payload, then a restart a couple
    // of bytes in with all-ones content so the checksum wraps many times.
    set_idling(0, 0);
    send_frame(FR_GOOD, 8'h00, 8'h00, FILL_ZERO, 0);
    send_frame(FR_RESTART, 8'hFF, 8'hFF, FILL_ONES, 2);
    drain();

    // Back-pressure: long output hold-off while two frames stream in at
    // full rate, so the result path fills and the second tail stalls. The
    // second frame has no start flag; the position has wrapped to 0.
    hold_req <= ~hold_req;
    send_frame(FR_GOOD, 8'($urandom), 8'($urandom), FILL_RANDOM, 0);
    send_frame(FR_NO_START, 8'($urandom), 8'($urandom), FILL_RANDOM, 0);
    drain();

    // Random part, up to the byte budget. Mostly well-formed frames with
    // random content; the rest corrupted, restarted or noise. Idling
    // cycles through: sender-heavy, receiver-heavy, light.
    frame_no = 0;
    while (items_sent + POS_TAIL / 2 < ITEM_TARGET) begin
      case (frame_no % 3)
        0:       set_idling(79, 0);
        1:       set_idling(0, 79);
        default: set_idling(7, 7);
      endcase

      pick = $urandom_range(0, 19);
      fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;

      pick = $urandom_range(0, 99);
      if (pick >= 94) begin
        send_noise($urandom_range(1, 12));
      end else begin
        kind = (pick < 55) ? FR_GOOD :
               (pick < 62) ? FR_BAD_HDR0 :
               (pick < 67) ? FR_BAD_HDR1 :
               (pick < 74) ? FR_BAD_TAIL :
               (pick < 81) ? FR_BAD_SUM :
               (pick < 88) ? FR_RESTART : FR_NO_START;
        send_frame(kind, 8'($urandom), 8'($urandom), fill, $urandom_range(1, POS_TAIL));
      end
      frame_no++;
    end

    // Wind down: everything predicted must arrive, then nothing else may.
    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
